### src/dcr_pkg.sv
// Shared types, class codes and arithmetic helpers for the DMX channel colour reducer.
// No dependencies; imported by the front end, queue, back end, top level and bench.
package dcr_pkg;

    localparam int NUM_MAXIMA    = 12;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [3:0] CLS_MASTER = 4'd0;
    localparam logic [3:0] CLS_WHITE  = 4'd7;
    localparam logic [3:0] CLS_WHEEL  = 4'd12;

    localparam logic [2:0] NUM_BLENDS = 3'd5;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // One complete set, handed from the front end to the back end.
    typedef struct packed {
        logic [NUM_MAXIMA-1:0][7:0] max_val;
        logic [NUM_MAXIMA-1:0]      seen;
        logic [7:0]                 wheel_r;
        logic [7:0]                 wheel_g;
        logic [7:0]                 wheel_b;
        logic                       wheel_seen;
        logic signed [8:0]          outer;
    } t_set;

    // floor(x / 255) for x below 65280, by reciprocal add and shift.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // Fixed colours for white, amber, UV, lime and indigo.
    function automatic logic [7:0] blend_target(input logic [2:0] bi, input logic [1:0] ci);
        logic [7:0] t;
        case ({bi, ci})
            {3'd0, 2'd0}: t = 8'd255;
            {3'd0, 2'd1}: t = 8'd255;
            {3'd0, 2'd2}: t = 8'd255;
            {3'd1, 2'd0}: t = 8'd255;
            {3'd1, 2'd1}: t = 8'd126;
            {3'd1, 2'd2}: t = 8'd0;
            {3'd2, 2'd0}: t = 8'd148;
            {3'd2, 2'd1}: t = 8'd0;
            {3'd2, 2'd2}: t = 8'd211;
            {3'd3, 2'd0}: t = 8'd173;
            {3'd3, 2'd1}: t = 8'd255;
            {3'd3, 2'd2}: t = 8'd47;
            {3'd4, 2'd0}: t = 8'd75;
            {3'd4, 2'd1}: t = 8'd0;
            {3'd4, 2'd2}: t = 8'd130;
            default:      t = 8'd0;
        endcase
        return t;
    endfunction

endpackage

### src/dcr_front.sv
// Front end: accepts channel items, tracks per-class maxima and the wheel colour.
// Pushes a finished set into the queue on the last channel. Depends on dcr_pkg.
module dcr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [3:0]     i_class,
    input  logic [7:0]     i_value,
    input  logic [7:0]     i_wheel_r,
    input  logic [7:0]     i_wheel_g,
    input  logic [7:0]     i_wheel_b,
    input  logic           i_wheel_hit,
    input  logic [8:0]     i_outer,
    input  logic           i_last,
    output logic           o_push,
    output dcr_pkg::t_set  o_set
);
    import dcr_pkg::*;

    logic [NUM_MAXIMA-1:0][7:0] r_max, n_max;
    logic [NUM_MAXIMA-1:0]      r_seen, n_seen;
    logic [7:0]                 r_wr, n_wr, r_wg, n_wg, r_wb, n_wb;
    logic                       r_wseen, n_wseen;

    always_comb begin
        n_max   = r_max;
        n_seen  = r_seen;
        n_wr    = r_wr;
        n_wg    = r_wg;
        n_wb    = r_wb;
        n_wseen = r_wseen;
        if (i_accept) begin
            if (i_class < 4'(NUM_MAXIMA)) begin
                if (!r_seen[i_class] || i_value > r_max[i_class]) begin
                    n_max[i_class]  = i_value;
                    n_seen[i_class] = 1'b1;
                end
            end else if (i_class == CLS_WHEEL && i_wheel_hit) begin
                n_wr    = i_wheel_r;
                n_wg    = i_wheel_g;
                n_wb    = i_wheel_b;
                n_wseen = 1'b1;
            end
        end
    end

    assign o_push           = i_accept && i_last;
    assign o_set.max_val    = n_max;
    assign o_set.seen       = n_seen;
    assign o_set.wheel_r    = n_wr;
    assign o_set.wheel_g    = n_wg;
    assign o_set.wheel_b    = n_wb;
    assign o_set.wheel_seen = n_wseen;
    assign o_set.outer      = i_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            // start the next set afresh
            r_max   <= '0;
            r_seen  <= '0;
            r_wr    <= '0;
            r_wg    <= '0;
            r_wb    <= '0;
            r_wseen <= 1'b0;
        end else begin
            r_max   <= n_max;
            r_seen  <= n_seen;
            r_wr    <= n_wr;
            r_wg    <= n_wg;
            r_wb    <= n_wb;
            r_wseen <= n_wseen;
        end
    end

endmodule

### src/dcr_queue.sv
// Short queue of finished sets between the front and back ends.
// Depends on dcr_pkg for the set type; DEPTH must be 2 or more.
module dcr_queue #(
    parameter int DEPTH = dcr_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcr_pkg::t_set  i_set,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output dcr_pkg::t_set  o_set
);
    import dcr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_set          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_set   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/dcr_back.sv
// Back end: sequencer that mixes the colour of one set, one blend component a cycle,
// then derives and scales the level and holds the result. Depends on dcr_pkg.
module dcr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_set_valid,
    input  dcr_pkg::t_set  i_set,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic           o_colour_valid,
    output logic [7:0]     o_level
);
    import dcr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_BLEND = 3'd2;
    localparam logic [2:0] S_LEVEL = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    t_set       r_set;
    logic [7:0] r_rgb [3];
    logic       r_found, r_valid;
    logic [2:0] r_bi;
    logic [1:0] r_ci;
    logic [7:0] r_level;

    logic        rgb_seen, cmy_seen;
    logic [3:0]  m_idx;
    logic [7:0]  m_val, tgt, a_cur;
    logic        m_seen;
    logic [16:0] mix_sum;
    logic [7:0]  sel_r, sel_g, sel_b, max3, lvl;
    logic [16:0] scale_sum;
    logic        emit_ok;

    assign rgb_seen = |r_set.seen[3:1];
    assign cmy_seen = |r_set.seen[6:4];

    // blend datapath
    assign m_idx   = CLS_WHITE + {1'b0, r_bi};
    assign m_val   = r_set.max_val[m_idx];
    assign m_seen  = r_set.seen[m_idx];
    assign tgt     = blend_target(r_bi, r_ci);
    assign a_cur   = r_rgb[r_ci];
    assign mix_sum = 17'(a_cur * (FULL_SCALE - m_val)) + 17'(tgt * m_val) + 17'd127;

    // level datapath
    always_comb begin
        if (!r_found && r_set.wheel_seen) begin
            sel_r = r_set.wheel_r;
            sel_g = r_set.wheel_g;
            sel_b = r_set.wheel_b;
        end else begin
            sel_r = r_rgb[0];
            sel_g = r_rgb[1];
            sel_b = r_rgb[2];
        end
        max3 = sel_r;
        if (sel_g > max3) max3 = sel_g;
        if (sel_b > max3) max3 = sel_b;
        if (r_set.seen[CLS_MASTER]) begin
            lvl = r_set.max_val[CLS_MASTER];
        end else if (cmy_seen && !rgb_seen) begin
            lvl = FULL_SCALE;
        end else if (r_found || r_set.wheel_seen) begin
            lvl = max3;
        end else begin
            lvl = 8'd0;
        end
        // black mix forces the level off
        if (r_found && sel_r == 8'd0 && sel_g == 8'd0 && sel_b == 8'd0) begin
            lvl = 8'd0;
        end
    end

    assign scale_sum = 17'(r_level * r_set.outer[7:0]) + 17'd127;
    assign emit_ok   = !o_tvalid || i_tready;
    assign o_pop     = (r_state == S_IDLE) && i_set_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_tvalid <= 1'b0;
        end else begin
            // raise on a new result, drop once the held transaction is taken
            if (r_state == S_EMIT && emit_ok) begin
                o_tvalid <= 1'b1;
            end else if (o_tvalid && i_tready) begin
                o_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_set_valid) begin
                        r_set   <= i_set;
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    for (int k = 0; k < 3; k++) begin
                        if (cmy_seen) begin
                            r_rgb[k] <= FULL_SCALE - r_set.max_val[4 + k];
                        end else if (rgb_seen) begin
                            r_rgb[k] <= r_set.max_val[1 + k];
                        end else begin
                            r_rgb[k] <= 8'd0;
                        end
                    end
                    r_found <= rgb_seen || cmy_seen || (|r_set.seen[11:7]);
                    r_bi    <= '0;
                    r_ci    <= '0;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    if (m_seen && m_val != 8'd0) begin
                        r_rgb[r_ci] <= div255(mix_sum[15:0]);
                    end
                    if (r_ci == 2'd2) begin
                        r_ci <= '0;
                        r_bi <= r_bi + 1'b1;
                        if (r_bi == NUM_BLENDS - 1'b1) begin
                            r_state <= S_LEVEL;
                        end
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                S_LEVEL: begin
                    r_rgb[0] <= sel_r;
                    r_rgb[1] <= sel_g;
                    r_rgb[2] <= sel_b;
                    r_valid  <= r_found || r_set.wheel_seen;
                    r_level  <= lvl;
                    r_state  <= S_SCALE;
                end
                S_SCALE: begin
                    // outer master only when the set carried no master channel
                    if (!r_set.seen[CLS_MASTER] && !r_set.outer[8]) begin
                        r_level <= div255(scale_sum[15:0]);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) begin
            o_red          <= r_rgb[0];
            o_green        <= r_rgb[1];
            o_blue         <= r_rgb[2];
            o_colour_valid <= r_valid;
            o_level        <= r_level;
        end
    end

endmodule

### src/dmx_channel_colour_reducer_core.sv
// Top level of the DMX channel colour reducer: front end, set queue and back end.
// Depends on dcr_pkg, dcr_front, dcr_queue and dcr_back.
//
// Input stream: one lighting channel per transaction. s_axis_tuser carries the
// channel class, s_axis_tlast marks the last channel of a set (one fixture head).
// The front end takes one channel per cycle and keeps a running maximum per class
// and the latest wheel colour; s_axis_tready drops only while the set queue is full.
// Output stream: one transaction per set with the mixed colour, a colour-valid flag
// in m_axis_tuser and the dimmer level.
// Throughput: any number of channels at one per cycle. The back end finishes one set
// before it loads the next, through its sequencer (one blend component per cycle, 15
// in all, plus load, base, level, scale and emit steps; emit waits on m_axis_tready).
// A set's result reaches m_axis_tvalid after the queue and these steps.
// Reset clears the running state, empties the queue and drops m_axis_tvalid.
// A stalled receiver holds the result in the output register; the back end then
// holds one more finished set and the queue fills with up to QUEUE_DEPTH sets
// before the input is held off.
module dmx_channel_colour_reducer_core #(
    parameter int QUEUE_DEPTH = dcr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] channel_value, [15:8] wheel_red, [23:16] wheel_green,
    // [31:24] wheel_blue, [32] wheel_hit, [41:33] outer_master, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    // [3:0] channel_class
    input  logic [3:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] level
    output logic [31:0] m_axis_tdata,
    // [0] colour_valid
    output logic [0:0]  m_axis_tuser
);
    import dcr_pkg::*;

    logic accept, push, full, q_valid, pop;
    t_set front_set, q_set;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_class     (s_axis_tuser),
        .i_value     (s_axis_tdata[7:0]),
        .i_wheel_r   (s_axis_tdata[15:8]),
        .i_wheel_g   (s_axis_tdata[23:16]),
        .i_wheel_b   (s_axis_tdata[31:24]),
        .i_wheel_hit (s_axis_tdata[32]),
        .i_outer     (s_axis_tdata[41:33]),
        .i_last      (s_axis_tlast),
        .o_push      (push),
        .o_set       (front_set)
    );

    dcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_set   (front_set),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_set   (q_set)
    );

    dcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_set_valid    (q_valid),
        .i_set          (q_set),
        .o_pop          (pop),
        .o_tvalid       (m_axis_tvalid),
        .i_tready       (m_axis_tready),
        .o_red          (m_axis_tdata[7:0]),
        .o_green        (m_axis_tdata[15:8]),
        .o_blue         (m_axis_tdata[23:16]),
        .o_colour_valid (m_axis_tuser[0]),
        .o_level        (m_axis_tdata[31:24])
    );

endmodule

### src/dcr_checker.sv
// Port-level checks for the DMX channel colour reducer, bound to its top level.
// Depends on dmx_channel_colour_reducer_core.
module dcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // result register is empty coming out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // a set without colour reports black
    a_no_colour_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:0] == 24'd0)
        else $error("colour bits set without a valid colour");

    // a held result keeps its transaction
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind dmx_channel_colour_reducer_core dcr_checker u_dcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for dmx_channel_colour_reducer_core: directed and random channel sets,
// random stalls on both streams, results compared against a behavioural colour mixer.
// Depends on dcr_pkg and the RTL of the block.
module tb_top;
    import dcr_pkg::*;

    localparam logic [3:0] CH_RED     = 4'd1;
    localparam logic [3:0] CH_GREEN   = 4'd2;
    localparam logic [3:0] CH_BLUE    = 4'd3;
    localparam logic [3:0] CH_CYAN    = 4'd4;
    localparam logic [3:0] CH_MAGENTA = 4'd5;
    localparam logic [3:0] CH_YELLOW  = 4'd6;
    localparam logic [3:0] CH_AMBER   = 4'd8;
    localparam logic [3:0] CH_UV      = 4'd9;
    localparam logic [3:0] CH_LIME    = 4'd10;
    localparam logic [3:0] CH_INDIGO  = 4'd11;
    localparam logic [3:0] CH_IGNORED = 4'd13;
    localparam logic [3:0] CH_SPARE   = 4'd14;
    localparam logic [3:0] CH_TOP     = 4'd15;

    localparam int ITEM_TARGET     = 700;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 60;
    localparam int REPORT_LIMIT    = 20;

    typedef struct {
        logic [3:0]        cls;
        logic [7:0]        value;
        logic [7:0]        wheel_r;
        logic [7:0]        wheel_g;
        logic [7:0]        wheel_b;
        logic              wheel_hit;
        logic signed [8:0] outer;
        logic              last;
        bit                drain;
    } chan_item_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       valid;
        logic [7:0] level;
    } mix_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    dmx_channel_colour_reducer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mixer state for the set in progress: -1 means the class has not appeared.
    int          peak[NUM_MAXIMA];
    logic [23:0] wheel_rgb;
    bit          wheel_held;

    chan_item_t  channels_pending[$];
    mix_result_t mixes_expected[$];
    chan_item_t  on_bus;
    mix_result_t want;

    int errors = 0;
    int channels_sent = 0;
    int sets_sent = 0;
    int mixes_checked = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int cycle_no = 0;
    bit calm = 1'b0;
    bit long_hold_done = 1'b0;
    bit drain_next = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding", mixes_expected.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [23:0] tint_of(input int idx);
        case (idx)
            0:       return 24'hFFFFFF;
            1:       return 24'hFF7E00;
            2:       return 24'h9400D3;
            3:       return 24'hADFF2F;
            default: return 24'h4B0082;
        endcase
    endfunction

    function automatic int blend_toward(input int a, input int b, input int v);
        return (a * (255 - v) + b * v + 127) / 255;
    endfunction

    function automatic int gap_length();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [3:0] pick_class(input int flavour);
        int r;
        r = $urandom_range(0, 9);
        case (flavour)
            1: return (r < 2) ? CLS_MASTER : 4'($urandom_range(CH_RED, CH_BLUE));
            2: return (r < 1) ? CLS_MASTER : 4'($urandom_range(CH_CYAN, CH_YELLOW));
            3: return (r < 3) ? 4'($urandom_range(CH_RED, CH_BLUE))
                              : 4'($urandom_range(CLS_WHITE, CH_INDIGO));
            4: begin
                if (r < 6)
                    return CLS_WHEEL;
                if (r < 8)
                    return 4'($urandom_range(CH_IGNORED, CH_TOP));
                return CLS_MASTER;
            end
            default: return 4'($urandom_range(CLS_MASTER, CH_TOP));
        endcase
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 255;
        if (r == 2)
            return 1;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic signed [8:0] pick_outer();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 9'($urandom_range(256, 511));
        if (r == 3)
            return 9'sd0;
        if (r == 4)
            return 9'sd255;
        return 9'($urandom_range(0, 255));
    endfunction

    task automatic clear_set();
        for (int i = 0; i < NUM_MAXIMA; i++)
            peak[i] = -1;
        wheel_rgb = '0;
        wheel_held = 1'b0;
    endtask

    task automatic add_item(input logic [3:0] cls, input int value, input int wr, wg, wb,
                            input bit hit, input logic signed [8:0] outer, input bit last);
        chan_item_t it;
        it.cls       = cls;
        it.value     = 8'(value);
        it.wheel_r   = 8'(wr);
        it.wheel_g   = 8'(wg);
        it.wheel_b   = 8'(wb);
        it.wheel_hit = hit;
        it.outer     = outer;
        it.last      = last;
        it.drain     = drain_next;
        drain_next   = 1'b0;
        channels_pending.push_back(it);
    endtask

    task automatic add_plain(input logic [3:0] cls, input int value, input bit last,
                             input logic signed [8:0] outer);
        add_item(cls, value, 0, 0, 0, 1'b0, outer, last);
    endtask

    // Fold one channel into the set; on the last channel mix the colour and queue it.
    task automatic mix_colour(input chan_item_t it);
        int          rgb[3];
        int          lvl;
        int          m;
        bit          rgb_seen;
        bit          cmy_seen;
        bit          found;
        logic [23:0] t;
        mix_result_t r;
        if (it.cls < NUM_MAXIMA) begin
            if (int'(it.value) > peak[it.cls])
                peak[it.cls] = it.value;
        end else if (it.cls == CLS_WHEEL && it.wheel_hit) begin
            wheel_rgb  = {it.wheel_r, it.wheel_g, it.wheel_b};
            wheel_held = 1'b1;
        end
        if (!it.last)
            return;

        rgb_seen = peak[CH_RED] >= 0 || peak[CH_GREEN] >= 0 || peak[CH_BLUE] >= 0;
        cmy_seen = peak[CH_CYAN] >= 0 || peak[CH_MAGENTA] >= 0 || peak[CH_YELLOW] >= 0;
        found = rgb_seen || cmy_seen;
        for (int k = 0; k < 3; k++) begin
            rgb[k] = 0;
            if (rgb_seen)
                rgb[k] = (peak[CH_RED + k] < 0) ? 0 : peak[CH_RED + k];
            // CMY overrides RGB as the complement of each CMY peak
            if (cmy_seen)
                rgb[k] = 255 - ((peak[CH_CYAN + k] < 0) ? 0 : peak[CH_CYAN + k]);
        end
        for (int i = 0; i < NUM_BLENDS; i++) begin
            m = peak[CLS_WHITE + i];
            if (m >= 0) begin
                found = 1'b1;
                t = tint_of(i);
                if (m > 0)
                    for (int k = 0; k < 3; k++)
                        rgb[k] = blend_toward(rgb[k], int'(t[23 - 8 * k -: 8]), m);
            end
        end
        r.valid = found;
        if (!found && wheel_held) begin
            rgb[0]  = wheel_rgb[23:16];
            rgb[1]  = wheel_rgb[15:8];
            rgb[2]  = wheel_rgb[7:0];
            r.valid = 1'b1;
        end

        if (peak[CLS_MASTER] >= 0)
            lvl = peak[CLS_MASTER];
        else if (cmy_seen && !rgb_seen)
            lvl = 255;
        else if (r.valid)
            lvl = (rgb[0] > rgb[1]) ? ((rgb[0] > rgb[2]) ? rgb[0] : rgb[2])
                                    : ((rgb[1] > rgb[2]) ? rgb[1] : rgb[2]);
        else
            lvl = 0;
        // black mix kills the level
        if (found && rgb[0] == 0 && rgb[1] == 0 && rgb[2] == 0)
            lvl = 0;
        if (peak[CLS_MASTER] < 0 && int'(it.outer) >= 0)
            lvl = (lvl * int'(it.outer) * 2 + 255) / 510;

        r.red   = 8'(rgb[0]);
        r.green = 8'(rgb[1]);
        r.blue  = 8'(rgb[2]);
        r.level = 8'(lvl);
        mixes_expected.push_back(r);
        clear_set();
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            if (errors < REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Channel driver: hold the current transaction until taken, then move to the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                mix_colour(on_bus);
                channels_sent++;
                if (on_bus.last)
                    sets_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (channels_pending.size() > 0 &&
                             !(channels_pending[0].drain && mixes_expected.size() > 0)) begin
                    on_bus = channels_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, on_bus.outer, on_bus.wheel_hit, on_bus.wheel_b,
                                      on_bus.wheel_g, on_bus.wheel_r, on_bus.value};
                    s_axis_tuser  <= on_bus.cls;
                    s_axis_tlast  <= on_bus.last;
                    send_gap = gap_length();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off to fill the set queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            cycle_no++;
            if (cycle_no % 256 == 0)
                calm <= ($urandom_range(0, 3) == 0);
            if (!long_hold_done && mixes_checked >= 25) begin
                long_hold_done = 1'b1;
                recv_gap = HOLD_OFF_CYCLES;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    recv_gap = gap_length();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mixes_expected.size() == 0) begin
                if (errors < REPORT_LIMIT)
                    $display("%0t: result with none expected, tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = mixes_expected.pop_front();
                check_field("red", want.red, m_axis_tdata[7:0]);
                check_field("green", want.green, m_axis_tdata[15:8]);
                check_field("blue", want.blue, m_axis_tdata[23:16]);
                check_field("level", want.level, m_axis_tdata[31:24]);
                check_field("colour_valid", {7'd0, want.valid}, {7'd0, m_axis_tuser[0]});
            end
            mixes_checked++;
        end
    end

    initial begin
        int flavour;
        int len;
        int set_no;
        int r;
        clear_set();

        // nothing but an ignored class: no colour, no level
        add_plain(CH_IGNORED, 255, 1'b1, -9'sd1);
        // RGB with a repeated red, full outer master
        add_plain(CH_RED, 255, 1'b0, -9'sd1);
        add_plain(CH_GREEN, 0, 1'b0, -9'sd1);
        add_plain(CH_BLUE, 128, 1'b0, -9'sd1);
        add_plain(CH_RED, 17, 1'b1, 9'sd255);
        // CMY alone gives full level
        add_plain(CH_CYAN, 0, 1'b1, -9'sd1);
        // zero white still counts as seen, black mix forces level to zero
        add_plain(CLS_MASTER, 0, 1'b0, -9'sd1);
        add_plain(CLS_WHITE, 0, 1'b1, 9'sd100);
        // wheel fallback: a miss after a hit leaves the hit colour
        add_item(CLS_WHEEL, 0, 8'hFF, 8'h00, 8'hAA, 1'b1, -9'sd1, 1'b0);
        add_item(CLS_WHEEL, 77, 8'h12, 8'h34, 8'h56, 1'b0, -9'sd1, 1'b0);
        add_plain(CH_TOP, 200, 1'b1, 9'sd0);
        // chain of blends with half outer master
        add_plain(CH_AMBER, 200, 1'b0, -9'sd1);
        add_plain(CH_UV, 255, 1'b0, -9'sd1);
        add_plain(CH_LIME, 128, 1'b0, -9'sd1);
        add_plain(CH_INDIGO, 1, 1'b1, 9'sd128);
        // CMY over RGB with master, most negative outer master
        add_plain(CH_MAGENTA, 255, 1'b0, -9'sd1);
        add_plain(CH_YELLOW, 255, 1'b0, -9'sd1);
        add_plain(CH_RED, 10, 1'b0, -9'sd1);
        add_plain(CLS_MASTER, 255, 1'b0, -9'sd1);
        add_plain(CH_SPARE, 9, 1'b1, -9'sd256);
        // wheel hit on the last channel itself
        add_item(CLS_WHEEL, 1, 8'h01, 8'hFE, 8'h80, 1'b1, 9'sd255, 1'b1);
        // all-zero RGB is a black mix
        add_plain(CH_RED, 0, 1'b0, -9'sd1);
        add_plain(CH_BLUE, 0, 1'b1, 9'sd200);

        set_no = 0;
        while (channels_pending.size() < ITEM_TARGET) begin
            // drain before a few sets so the sender waits on an empty pipeline
            if (set_no == 0 || set_no == 70 || set_no == 110)
                drain_next = 1'b1;
            flavour = $urandom_range(0, 4);
            r = $urandom_range(0, 19);
            if (r < 15)
                len = $urandom_range(1, 6);
            else if (r < 19)
                len = $urandom_range(7, 16);
            else
                len = $urandom_range(17, 40);
            for (int j = 0; j < len; j++)
                add_item(pick_class(flavour), pick_value(), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 1), pick_outer(), j == len - 1);
            set_no++;
        end

        wait (i_rst_n);
        while (channels_pending.size() > 0 || s_axis_tvalid || mixes_expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Drove %0d channels in %0d sets and compared %0d colour results, %0d errors.",
                 channels_sent, sets_sent, mixes_checked, errors);
        $display("Covered corner sets, random mixes, wheel fallback, output hold-off and drains.");
        if (errors == 0 && mixes_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
src/dcr_pkg.sv
src/dcr_front.sv
src/dcr_queue.sv
src/dcr_back.sv
src/dmx_channel_colour_reducer_core.sv
src/dcr_checker.sv
test/tb_top.sv
